FILE: rtl/tdg_pkg.sv
// Shared codes, field widths and register indexes for the tap and drag gesture recogniser.
package tdg_pkg;

  // Button event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  // Gesture phase codes
  localparam logic [2:0] PH_START    = 3'd0;
  localparam logic [2:0] PH_TOUCH    = 3'd1;
  localparam logic [2:0] PH_MOVE     = 3'd2;
  localparam logic [2:0] PH_PENDING  = 3'd3;
  localparam logic [2:0] PH_POSSIBLE = 3'd4;
  localparam logic [2:0] PH_DRAG     = 3'd5;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_ON   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_OFF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_DIST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_EN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLICKPAD   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_TMO    = 3'd6;

  // Fixed field widths
  localparam int unsigned EVENT_W     = 2;
  localparam int unsigned PHASE_W     = 3;
  localparam int unsigned TIMEOUT_W   = 16;
  localparam int unsigned MAX_EVENTS  = 4;
  localparam int unsigned EV_IDX_W    = 2;
  localparam int unsigned OUT_TDATA_W = 8;

endpackage

FILE: rtl/tap_drag_gesture_recognizer.sv
// Tap and drag gesture recogniser: input register, single-pass update, result beat buffer.
//
//  Channel   | Direction | Handshake                    | Payload
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata: packet fields, tuser: cmd
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata: event/contact/phase, tlast
//  cfg       | in        | cfg_we_i                     | cfg_idx_i, cfg_data_i
//
// An item waits in the input register and is handled in one pass into the result buffer,
// which then gives one beat per cycle while m_axis_tready is high: 1 to 4 beats per item
// (1 for an item with no event, 4 for a double tap).
// The input register takes the next beat while results still drain.
// Reset (asynchronous, active low) clears contact, phase, timer and both valid flags.
// A stalled output holds its beat; the input register then fills and tready drops.
module tap_drag_gesture_recognizer #(
  parameter int unsigned COORD_BITS    = 13,
  parameter int unsigned PRESSURE_BITS = 8,
  parameter int unsigned TIMER_BITS    = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata, low bit up: pos_x, pos_x_valid, pos_y, pos_y_valid, press_value, press_valid, zeros
  input  logic [((2*COORD_BITS+PRESSURE_BITS+3+7)/8)*8-1:0] s_axis_tdata,
  // tuser: cmd (0 touch packet, 1 timer tick)
  input  logic                            s_axis_tuser,
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata, low bit up: button_event[1:0], finger_down, gesture_phase[2:0], zeros
  output logic [tdg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // tlast: last_of_run
  output logic                            m_axis_tlast,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [tdg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [((COORD_BITS > PRESSURE_BITS) ?
                 ((COORD_BITS > 16) ? COORD_BITS : 16) :
                 ((PRESSURE_BITS > 16) ? PRESSURE_BITS : 16))-1:0] cfg_data_i
);
  import tdg_pkg::*;

  localparam int unsigned IN_W       = 2*COORD_BITS + PRESSURE_BITS + 3;
  localparam int unsigned OFF_XV     = COORD_BITS;
  localparam int unsigned OFF_Y      = COORD_BITS + 1;
  localparam int unsigned OFF_YV     = 2*COORD_BITS + 1;
  localparam int unsigned OFF_P      = 2*COORD_BITS + 2;
  localparam int unsigned OFF_PV     = 2*COORD_BITS + PRESSURE_BITS + 2;

  // Configuration registers
  logic [PRESSURE_BITS-1:0] press_on_q, press_off_q;
  logic [COORD_BITS-1:0]    move_dist_q, bottom_q;
  logic                     tap_en_q, clickpad_q;
  logic [TIMEOUT_W-1:0]     tap_tmo_q;

  // Input register
  logic                     in_valid_q;
  logic [IN_W-1:0]          in_data_q;
  logic                     in_cmd_q;

  // Gesture state
  logic                     contact_q, contact_d;
  logic                     prev_contact_q, prev_contact_d;
  logic [COORD_BITS-1:0]    last_x_q, last_x_d, last_y_q, last_y_d;
  logic [COORD_BITS-1:0]    tp_x_q, tp_x_d, tp_y_q, tp_y_d;
  logic                     bottom_on_q, bottom_on_d;
  logic [PHASE_W-1:0]       phase_q, phase_d;
  logic [TIMER_BITS-1:0]    timer_q, timer_d;

  // Result buffer
  logic                     out_valid_q;
  logic [EVENT_W-1:0]       ev_q [MAX_EVENTS];
  logic [EVENT_W-1:0]       ev_d [MAX_EVENTS];
  logic [EV_IDX_W-1:0]      ev_last_q, ev_last_d;
  logic [EV_IDX_W-1:0]      ev_idx_q;
  logic [2:0]               ev_cnt;

  // Unpacked input fields
  logic [COORD_BITS-1:0]    x, y, dx, dy;
  logic                     xv, yv, pv;
  logic [PRESSURE_BITS-1:0] p;
  logic                     touch, release_ev, move, tap_ok;
  logic [TIMER_BITS-1:0]    tmo_ld;

  logic                     out_last, out_free, proc_fire, in_fire, out_fire;

  assign out_last  = (ev_idx_q == ev_last_q);
  assign out_fire  = out_valid_q && m_axis_tready;
  assign out_free  = !out_valid_q || (m_axis_tready && out_last);
  assign proc_fire = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || proc_fire;
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  assign x  = in_data_q[COORD_BITS-1:0];
  assign xv = in_data_q[OFF_XV];
  assign y  = in_data_q[OFF_Y +: COORD_BITS];
  assign yv = in_data_q[OFF_YV];
  assign p  = in_data_q[OFF_P +: PRESSURE_BITS];
  assign pv = in_data_q[OFF_PV];

  assign dx = (x >= tp_x_q) ? (x - tp_x_q) : (tp_x_q - x);
  assign dy = (y >= tp_y_q) ? (y - tp_y_q) : (tp_y_q - y);

  // Timeout load value; zero acts as one tick
  assign tmo_ld = (TIMER_BITS'(tap_tmo_q) == '0) ? TIMER_BITS'(1) : TIMER_BITS'(tap_tmo_q);

  // Work out the next state and the event list for the item in the input register
  always_comb begin
    contact_d      = contact_q;
    prev_contact_d = prev_contact_q;
    last_x_d       = last_x_q;
    last_y_d       = last_y_q;
    tp_x_d         = tp_x_q;
    tp_y_d         = tp_y_q;
    bottom_on_d    = bottom_on_q;
    phase_d        = phase_q;
    timer_d        = timer_q;
    ev_cnt         = 3'd0;
    for (int i = 0; i < MAX_EVENTS; i++) begin
      ev_d[i] = EV_NONE;
    end
    touch      = 1'b0;
    release_ev = 1'b0;
    move       = 1'b0;
    tap_ok     = 1'b0;

    if (in_cmd_q) begin
      // Timer tick: count down, send a pending tap on expiry
      if (timer_q != '0) begin
        timer_d = timer_q - TIMER_BITS'(1);
        if (timer_q == TIMER_BITS'(1) && phase_q == PH_PENDING) begin
          ev_d[0] = EV_PRESS;
          ev_d[1] = EV_RELEASE;
          ev_cnt  = 3'd2;
          phase_d = PH_START;
        end
      end
    end else begin
      // Pressure hysteresis
      if (pv) begin
        if (!contact_q) begin
          if (p > press_on_q) contact_d = 1'b1;
        end else if (p < press_off_q) begin
          contact_d = 1'b0;
        end
      end
      touch      = contact_d && !prev_contact_q;
      release_ev = !contact_d && prev_contact_q;
      move       = contact_d && !touch &&
                   ((xv && (dx >= move_dist_q)) || (yv && (dy >= move_dist_q)));

      // Latch the touch-down point
      if (touch) begin
        tp_x_d      = xv ? x : last_x_q;
        tp_y_d      = yv ? y : last_y_q;
        bottom_on_d = ((yv ? y : last_y_q) > bottom_q);
      end
      tap_ok = tap_en_q && !(clickpad_q && bottom_on_d);

      // Tap machine
      case (phase_q)
        PH_START: begin
          if (touch) phase_d = PH_TOUCH;
        end
        PH_TOUCH: begin
          if (move) begin
            phase_d = PH_MOVE;
          end else if (release_ev) begin
            phase_d = PH_START;
            if (tap_ok) begin
              timer_d = tmo_ld;
              phase_d = PH_PENDING;
            end
          end
        end
        PH_MOVE: begin
          if (release_ev) phase_d = PH_START;
        end
        PH_PENDING: begin
          if (touch) begin
            timer_d = '0;
            if (tap_ok) begin
              phase_d = PH_POSSIBLE;
            end else begin
              ev_d[0] = EV_PRESS;
              ev_d[1] = EV_RELEASE;
              ev_cnt  = 3'd2;
              phase_d = PH_TOUCH;
            end
          end
        end
        PH_POSSIBLE: begin
          if (move) begin
            ev_d[0] = EV_PRESS;
            ev_cnt  = 3'd1;
            phase_d = PH_DRAG;
          end else if (release_ev) begin
            ev_d[0] = EV_PRESS;
            ev_d[1] = EV_RELEASE;
            ev_d[2] = EV_PRESS;
            ev_d[3] = EV_RELEASE;
            ev_cnt  = 3'd4;
            phase_d = PH_START;
          end
        end
        PH_DRAG: begin
          if (release_ev) begin
            ev_d[0] = EV_RELEASE;
            ev_cnt  = 3'd1;
            phase_d = PH_START;
          end
        end
        default: begin
          phase_d = PH_START;
        end
      endcase

      prev_contact_d = contact_d;
      if (xv) last_x_d = x;
      if (yv) last_y_d = y;
    end

    // One beat even when there is no event
    ev_last_d = (ev_cnt == 3'd0) ? EV_IDX_W'(0) : EV_IDX_W'(ev_cnt - 3'd1);
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_on_q  <= PRESSURE_BITS'(30);
      press_off_q <= PRESSURE_BITS'(25);
      move_dist_q <= COORD_BITS'(100);
      bottom_q    <= COORD_BITS'(4000);
      tap_en_q    <= 1'b1;
      clickpad_q  <= 1'b0;
      tap_tmo_q   <= TIMEOUT_W'(180);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PRESS_ON:  press_on_q  <= cfg_data_i[PRESSURE_BITS-1:0];
        REG_PRESS_OFF: press_off_q <= cfg_data_i[PRESSURE_BITS-1:0];
        REG_MOVE_DIST: move_dist_q <= cfg_data_i[COORD_BITS-1:0];
        REG_BOTTOM:    bottom_q    <= cfg_data_i[COORD_BITS-1:0];
        REG_TAP_EN:    tap_en_q    <= cfg_data_i[0];
        REG_CLICKPAD:  clickpad_q  <= cfg_data_i[0];
        REG_TAP_TMO:   tap_tmo_q   <= cfg_data_i[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: hold the beat until it has been processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (proc_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_data_q <= s_axis_tdata[IN_W-1:0];
      in_cmd_q  <= s_axis_tuser;
    end
  end

  // Gesture state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contact_q      <= 1'b0;
      prev_contact_q <= 1'b0;
      last_x_q       <= '0;
      last_y_q       <= '0;
      tp_x_q         <= '0;
      tp_y_q         <= '0;
      bottom_on_q    <= 1'b0;
      phase_q        <= PH_START;
      timer_q        <= '0;
    end else if (proc_fire) begin
      contact_q      <= contact_d;
      prev_contact_q <= prev_contact_d;
      last_x_q       <= last_x_d;
      last_y_q       <= last_y_d;
      tp_x_q         <= tp_x_d;
      tp_y_q         <= tp_y_d;
      bottom_on_q    <= bottom_on_d;
      phase_q        <= phase_d;
      timer_q        <= timer_d;
    end
  end

  // Result buffer: load on processing, advance one beat per handshake
  logic                 res_contact_q;
  logic [PHASE_W-1:0]   res_phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ev_idx_q    <= '0;
      ev_last_q   <= '0;
    end else if (proc_fire) begin
      out_valid_q <= 1'b1;
      ev_idx_q    <= '0;
      ev_last_q   <= ev_last_d;
    end else if (out_fire) begin
      if (out_last) begin
        out_valid_q <= 1'b0;
      end else begin
        ev_idx_q <= ev_idx_q + EV_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      for (int i = 0; i < MAX_EVENTS; i++) begin
        ev_q[i] <= ev_d[i];
      end
      res_contact_q <= contact_d;
      res_phase_q   <= phase_d;
    end
  end

  // Drive the result beat
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {2'b00, res_phase_q, res_contact_q, ev_q[ev_idx_q]};

  logic unused_pad;
  assign unused_pad = ^s_axis_tdata;

endmodule

FILE: sim/tb_tap_drag_gesture_recognizer.sv
// Self-checking testbench for the tap and drag gesture recogniser: directed, then random gestures.
module tb_tap_drag_gesture_recognizer;
  import tdg_pkg::*;

  localparam int unsigned COORD_W   = 13;
  localparam int unsigned PRESS_W   = 8;
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned COORD_MAX = 8191;
  // Index with no register behind it; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [EVENT_W-1:0] button;
    logic               finger;
    logic [PHASE_W-1:0] phase;
    logic               last;
  } gesture_beat_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // tdata, low bit up: pos_x, pos_x_valid, pos_y, pos_y_valid, press_value, press_valid, zeros
  logic [IN_DATA_W-1:0] s_axis_tdata;
  // tuser: cmd (0 touch packet, 1 timer tick)
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // tdata, low bit up: button_event, finger_down, gesture_phase, zeros
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  // Register copies
  logic [PRESS_W-1:0]   on_level, off_level;
  logic [COORD_W-1:0]   move_dist, bottom_line;
  logic                 tap_en, clickpad;
  logic [TIMEOUT_W-1:0] tmo_ticks;

  // Gesture state copies
  logic                 contact, prev_contact, touch_bottom;
  logic [COORD_W-1:0]   last_x, last_y, touch_x, touch_y;
  logic [PHASE_W-1:0]   phase_q;
  logic [TIMEOUT_W-1:0] tap_timer;

  gesture_beat_t button_beats_due[$];
  int unsigned   mismatch_count = 0;
  int unsigned   items_sent = 0;
  int unsigned   send_idle_pct = 21;
  int unsigned   recv_idle_pct = 48;

  tap_drag_gesture_recognizer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic string beat_text(gesture_beat_t b);
    return $sformatf("ev=%0d finger=%0d phase=%0d last=%0d",
                     b.button, b.finger, b.phase, b.last);
  endfunction

  // Compare each result beat with the oldest due beat
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (button_beats_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat, expected none, actual tdata=%h tlast=%0b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        gesture_beat_t want, got;
        want = button_beats_due.pop_front();
        got  = {m_axis_tdata[1:0], m_axis_tdata[2], m_axis_tdata[5:3], m_axis_tlast};
        if (got !== want) begin
          mismatch_count++;
          $display("%0t: mismatch, expected %s, actual %s", $time, beat_text(want),
                   beat_text(got));
        end
      end
    end
  end

  function automatic logic chance(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [COORD_W-1:0] coord_dist(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic tap_allowed();
    return tap_en && !(clickpad && touch_bottom);
  endfunction

  // Advance the gesture state by one item and queue the beats it gives
  task automatic advance_gesture(input logic cmd, input logic [COORD_W-1:0] x, input logic xv,
                                 input logic [COORD_W-1:0] y, input logic yv,
                                 input logic [PRESS_W-1:0] p, input logic pv);
    logic [EVENT_W-1:0] events[$];
    logic               touch, lift, moved;
    gesture_beat_t      b;
    if (cmd) begin
      if (tap_timer != 0) begin
        tap_timer = tap_timer - 1'b1;
        if (tap_timer == 0 && phase_q == PH_PENDING) begin
          events.push_back(EV_PRESS);
          events.push_back(EV_RELEASE);
          phase_q = PH_START;
        end
      end
    end else begin
      // Pressure hysteresis
      if (pv) begin
        if (!contact) begin
          if (p > on_level) contact = 1'b1;
        end else if (p < off_level) begin
          contact = 1'b0;
        end
      end
      touch = contact && !prev_contact;
      lift  = !contact && prev_contact;
      moved = contact && !touch &&
              ((xv && coord_dist(x, touch_x) >= move_dist) ||
               (yv && coord_dist(y, touch_y) >= move_dist));
      if (touch) begin
        touch_x      = xv ? x : last_x;
        touch_y      = yv ? y : last_y;
        touch_bottom = touch_y > bottom_line;
      end
      case (phase_q)
        PH_START: begin
          if (touch) phase_q = PH_TOUCH;
        end
        PH_TOUCH: begin
          if (moved) begin
            phase_q = PH_MOVE;
          end else if (lift) begin
            phase_q = PH_START;
            if (tap_allowed()) begin
              tap_timer = (tmo_ticks == '0) ? TIMEOUT_W'(1) : tmo_ticks;
              phase_q   = PH_PENDING;
            end
          end
        end
        PH_MOVE: begin
          if (lift) phase_q = PH_START;
        end
        PH_PENDING: begin
          if (touch) begin
            tap_timer = '0;
            if (tap_allowed()) begin
              phase_q = PH_POSSIBLE;
            end else begin
              events.push_back(EV_PRESS);
              events.push_back(EV_RELEASE);
              phase_q = PH_TOUCH;
            end
          end
        end
        PH_POSSIBLE: begin
          if (moved) begin
            events.push_back(EV_PRESS);
            phase_q = PH_DRAG;
          end else if (lift) begin
            phase_q = PH_START;
            events.push_back(EV_PRESS);
            events.push_back(EV_RELEASE);
            events.push_back(EV_PRESS);
            events.push_back(EV_RELEASE);
          end
        end
        PH_DRAG: begin
          if (lift) begin
            phase_q = PH_START;
            events.push_back(EV_RELEASE);
          end
        end
        default: phase_q = PH_START;
      endcase
      prev_contact = contact;
      if (xv) last_x = x;
      if (yv) last_y = y;
    end
    if (events.size() == 0) events.push_back(EV_NONE);
    foreach (events[k]) begin
      b.button = events[k];
      b.finger = contact;
      b.phase  = phase_q;
      b.last   = (k == events.size() - 1);
      button_beats_due.push_back(b);
    end
  endtask

  // Offer one beat after a random gap and predict it once accepted
  task automatic send_item(input logic cmd, input logic [COORD_W-1:0] x, input logic xv,
                           input logic [COORD_W-1:0] y, input logic yv,
                           input logic [PRESS_W-1:0] p, input logic pv);
    while (chance(send_idle_pct)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, pv, p, yv, y, xv, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    advance_gesture(cmd, x, xv, y, yv, p, pv);
    items_sent++;
  endtask

  task automatic send_packet(input int unsigned x, input int unsigned y, input int unsigned p);
    send_item(1'b0, COORD_W'(x), 1'b1, COORD_W'(y), 1'b1, PRESS_W'(p), 1'b1);
  endtask

  // Ticks carry random junk in the packet fields
  task automatic send_tick();
    send_item(1'b1, COORD_W'($urandom_range(COORD_MAX)), 1'($urandom_range(1)),
              COORD_W'($urandom_range(COORD_MAX)), 1'($urandom_range(1)),
              PRESS_W'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // Drop tvalid and wait until every due beat has arrived
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (button_beats_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_PRESS_ON:  on_level    = value[PRESS_W-1:0];
      REG_PRESS_OFF: off_level   = value[PRESS_W-1:0];
      REG_MOVE_DIST: move_dist   = value[COORD_W-1:0];
      REG_BOTTOM:    bottom_line = value[COORD_W-1:0];
      REG_TAP_EN:    tap_en      = value[0];
      REG_CLICKPAD:  clickpad    = value[0];
      REG_TAP_TMO:   tmo_ticks   = value[TIMEOUT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int unsigned on, input int unsigned off, input int unsigned mv,
                           input int unsigned bot, input int unsigned en, input int unsigned cp,
                           input int unsigned tmo);
    write_reg(REG_PRESS_ON, CFG_W'(on));
    write_reg(REG_PRESS_OFF, CFG_W'(off));
    write_reg(REG_MOVE_DIST, CFG_W'(mv));
    write_reg(REG_BOTTOM, CFG_W'(bot));
    write_reg(REG_TAP_EN, CFG_W'(en));
    write_reg(REG_CLICKPAD, CFG_W'(cp));
    write_reg(REG_TAP_TMO, CFG_W'(tmo));
  endtask

  // Pressure samples that start or end contact under the current levels
  function automatic logic [PRESS_W-1:0] press_high();
    return (on_level == 8'hFF) ? 8'hFF : PRESS_W'($urandom_range(255, on_level + 1));
  endfunction

  function automatic logic [PRESS_W-1:0] press_low();
    return (off_level == 0) ? 8'h00 : PRESS_W'($urandom_range(off_level - 1, 0));
  endfunction

  function automatic logic [COORD_W-1:0] near_of(logic [COORD_W-1:0] c);
    int v, d;
    d = (move_dist > 1) ? $urandom_range(move_dist - 1, 0) : 0;
    v = $urandom_range(1) ? int'(c) + d : int'(c) - d;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v[COORD_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] far_from(logic [COORD_W-1:0] c);
    int v;
    v = int'(c) + int'(move_dist) + $urandom_range(200);
    if (v > COORD_MAX) v = int'(c) - int'(move_dist) - $urandom_range(200);
    if (v < 0) v = 0;
    return v[COORD_W-1:0];
  endfunction

  task automatic touch_at(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    send_item(1'b0, x, chance(90), y, chance(90), press_high(), 1'b1);
  endtask

  task automatic hold_near(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    send_item(1'b0, near_of(x), chance(85), near_of(y), chance(85),
              chance(80) ? press_high() : PRESS_W'($urandom_range(255)), chance(85));
  endtask

  task automatic lift_at(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    send_item(1'b0, near_of(x), chance(80), near_of(y), chance(80), press_low(), 1'b1);
  endtask

  task automatic tap_at(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    touch_at(x, y);
    repeat ($urandom_range(2)) hold_near(x, y);
    lift_at(x, y);
  endtask

  // One random gesture: mostly well-formed taps, drags and moves, some noise
  task automatic random_gesture();
    logic [COORD_W-1:0] px, py;
    int unsigned        kind, n;
    px   = COORD_W'($urandom_range(COORD_MAX));
    py   = COORD_W'($urandom_range(COORD_MAX));
    kind = $urandom_range(9);
    case (kind)
      0, 1, 2: begin
        tap_at(px, py);
        n = (tmo_ticks < 6) ? tmo_ticks : 6;
        repeat ($urandom_range(n + 1)) send_tick();
      end
      3, 4: begin
        tap_at(px, py);
        if (chance(30)) send_tick();
        touch_at(near_of(px), near_of(py));
        if (chance(40)) hold_near(px, py);
        lift_at(px, py);
      end
      5, 6: begin
        tap_at(px, py);
        touch_at(near_of(px), near_of(py));
        repeat ($urandom_range(3, 1)) begin
          send_item(1'b0, far_from(px), 1'b1, far_from(py), chance(70), press_high(),
                    chance(90));
        end
        lift_at(px, py);
      end
      7: begin
        touch_at(px, py);
        send_item(1'b0, far_from(px), chance(80), far_from(py), 1'b1, press_high(), 1'b1);
        lift_at(px, py);
      end
      8: begin
        send_item(1'b0, COORD_W'($urandom_range(COORD_MAX)), 1'($urandom_range(1)),
                  COORD_W'($urandom_range(COORD_MAX)), 1'($urandom_range(1)),
                  PRESS_W'($urandom_range(255)), 1'($urandom_range(1)));
      end
      default: begin
        repeat ($urandom_range(3, 1)) send_tick();
      end
    endcase
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) random_gesture();
  endtask

  // Double tap under reset levels, with extreme pressures
  task automatic test_double_tap();
    send_packet(1000, 1000, 255);
    send_packet(1000, 1000, 0);
    send_packet(1010, 1010, 200);
    send_packet(1010, 1010, 0);
  endtask

  // Tap, touch again and move: press held until the finger lifts
  task automatic test_tap_drag();
    send_packet(1000, 1010, 200);
    send_packet(1000, 1010, 0);
    send_packet(1005, 1010, 200);
    send_packet(1500, 1010, 200);
    send_packet(1500, 1010, 0);
  endtask

  // Missing fields, pressure at both thresholds, coordinates at both ends
  task automatic test_partial_fields();
    send_item(1'b0, 13'd8191, 1'b0, 13'd0, 1'b0, 8'd30, 1'b1);
    send_item(1'b0, 13'd0, 1'b0, 13'd8191, 1'b0, 8'd255, 1'b1);
    send_item(1'b0, 13'd8191, 1'b1, 13'd0, 1'b0, 8'd0, 1'b0);
    send_packet(8191, 8191, 25);
    send_packet(0, 0, 24);
  endtask

  // Zero timeout acts as one tick; a tick with no timer running does nothing
  task automatic test_tap_timeout();
    drain();
    write_reg(REG_TAP_TMO, 16'd0);
    send_tick();
    send_packet(2000, 2000, 100);
    send_packet(2000, 2000, 0);
    send_tick();
  endtask

  // Clickpad bottom-edge taps and taps with tap-to-click off give no click; a top-edge tap does
  task automatic test_no_tap_cases();
    drain();
    write_reg(REG_CLICKPAD, 16'd1);
    write_reg(REG_BOTTOM, 16'd0);
    send_packet(3000, 8191, 100);
    send_packet(3000, 8191, 0);
    send_packet(3000, 0, 100);
    send_packet(3000, 0, 0);
    send_packet(3000, 5000, 100);
    send_packet(3000, 5000, 0);
    drain();
    write_reg(REG_TAP_EN, 16'd0);
    send_packet(3000, 0, 100);
    send_packet(3000, 0, 0);
  endtask

  task automatic test_random_moderate();
    drain();
    send_idle_pct = 21;
    recv_idle_pct = 48;
    write_all(40, 20, 50, 6000, 1, 1, 3);
    write_reg(REG_UNUSED, 16'hFFFF);
    run_random(50);
  endtask

  task automatic test_random_low_levels();
    drain();
    send_idle_pct = 48;
    recv_idle_pct = 21;
    write_all(0, 1, 0, 0, 1, 0, 1);
    run_random(40);
  endtask

  task automatic test_random_no_idle();
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all(200, 150, 300, 8191, 1, 1, 2);
    run_random(40);
    // Top levels and wide values that must be cut to the register widths
    drain();
    write_reg(REG_PRESS_ON, 16'hFFFF);
    write_reg(REG_PRESS_OFF, 16'd255);
    write_reg(REG_MOVE_DIST, 16'hFFFF);
    write_reg(REG_TAP_TMO, 16'hFFFF);
    write_reg(REG_TAP_EN, 16'hFFFE);
    run_random(10);
  endtask

  initial begin
    on_level      = 30;
    off_level     = 25;
    move_dist     = 100;
    bottom_line   = 4000;
    tap_en        = 1'b1;
    clickpad      = 1'b0;
    tmo_ticks     = 180;
    contact       = 1'b0;
    prev_contact  = 1'b0;
    last_x        = '0;
    last_y        = '0;
    touch_x       = '0;
    touch_y       = '0;
    touch_bottom  = 1'b0;
    phase_q       = PH_START;
    tap_timer     = '0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_double_tap();
    test_tap_drag();
    test_partial_fields();
    test_tap_timeout();
    test_no_tap_cases();
    test_random_moderate();
    test_random_low_levels();
    test_random_no_idle();
    drain();

    if (mismatch_count == 0 && button_beats_due.size() == 0) begin
      $display("tap_drag_gesture_recognizer verification clean");
    end else begin
      $display("tap_drag_gesture_recognizer verification failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5000000;
    $display("tap_drag_gesture_recognizer verification failed");
    $finish;
  end

endmodule
